// ===== rtl/core/ccpg_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, reset values and register codes of the color cube patch pattern generator.
package ccpg_pkg;

	localparam int PIX_BITS         = 12;
	localparam int LUT_BITS         = 6;
	localparam int CFG_IDX_BITS     = 2;
	localparam int CFG_DATA_BITS    = 12;

	localparam int DEF_PATCH_SIZE   = 7;
	localparam int DEF_MAX_LUT_SIZE = 33;
	localparam int DEF_COLOR_BITS   = 16;

	localparam int LUT_SIZE_MIN     = 2;

	localparam logic [LUT_BITS-1:0] RST_LUT_SIZE     = 6'd33;
	localparam logic [PIX_BITS-1:0] RST_FRAME_WIDTH  = 12'd1323;
	localparam logic [PIX_BITS-1:0] RST_FRAME_HEIGHT = 12'd1337;
	localparam logic                RST_ALPHA_EN     = 1'b1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_LUT_SIZE      = 2'd0,
		REG_FRAME_WIDTH   = 2'd1,
		REG_FRAME_HEIGHT  = 2'd2,
		REG_ALPHA_ENABLED = 2'd3
	} cfg_reg_t;

endpackage

// ===== rtl/core/ccpg_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces: pixel coordinates in, colors out, register writes.
interface ccpg_pix_if import ccpg_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [PIX_BITS-1:0] pixel_x;
	logic [PIX_BITS-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface ccpg_col_if import ccpg_pkg::*; #(
	parameter int COLOR_BITS = DEF_COLOR_BITS
) ();
	logic                  valid;
	logic                  ready;
	logic [COLOR_BITS-1:0] red_code;
	logic [COLOR_BITS-1:0] green_code;
	logic [COLOR_BITS-1:0] blue_code;
	logic [COLOR_BITS-1:0] alpha_code;
	logic                  in_patch;

	modport source (output valid, output red_code, output green_code, output blue_code,
		output alpha_code, output in_patch, input ready);
	modport sink (input valid, input red_code, input green_code, input blue_code,
		input alpha_code, input in_patch, output ready);
endinterface

interface ccpg_cfg_if import ccpg_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/color_cube_patch_pattern_generator.sv =====
`timescale 1ns / 1ps
// Color cube chart generator: one pixel coordinate in, that pixel's patch color out. It takes
// one pixel per clock until back pressure has filled the pipeline, and passes each through ten
// register stages: divide by patch size, patch index multiply-add, two reciprocal divides by
// the cube size for the color digits, and a reciprocal divide by cube size minus one for the
// level scaling. Every stage holds its item under back pressure, so the input stalls only
// once all stages and the output register are full. Registers must be written only while no
// pixel is in flight, which the block does not enforce; the register port never stalls.
module color_cube_patch_pattern_generator import ccpg_pkg::*; #(
	parameter int PATCH_SIZE   = DEF_PATCH_SIZE,
	parameter int MAX_LUT_SIZE = DEF_MAX_LUT_SIZE,
	parameter int COLOR_BITS   = DEF_COLOR_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	ccpg_cfg_if.sink cfg,
	ccpg_pix_if.sink pix,
	ccpg_col_if.source col
);

	localparam int SP  = PIX_BITS;
	localparam int PPW = PIX_BITS + SP + 1;
	localparam int NB  = $clog2(MAX_LUT_SIZE + 1);
	localparam int CB  = $clog2(MAX_LUT_SIZE * MAX_LUT_SIZE * MAX_LUT_SIZE);
	localparam int IB  = 2 * PIX_BITS + 1;
	localparam int SD  = 2 * NB;
	localparam int AW  = NB + COLOR_BITS;
	localparam int PBW = 2 * SD + 1;

	localparam longint unsigned MP_L   = (64'd1 << SP) / PATCH_SIZE;
	localparam logic [SP:0]     MP     = MP_L[SP:0];
	localparam logic [PIX_BITS-1:0] P_C = PIX_BITS'(PATCH_SIZE);
	localparam longint unsigned FULL_L = (64'd1 << COLOR_BITS) - 64'd1;
	localparam logic [COLOR_BITS-1:0] FULL = FULL_L[COLOR_BITS-1:0];

	// Registers
	logic [LUT_BITS-1:0] lut_size_q;
	logic [PIX_BITS-1:0] frame_width_q;
	logic [PIX_BITS-1:0] frame_height_q;
	logic                alpha_enabled_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lut_size_q      <= RST_LUT_SIZE;
			frame_width_q   <= RST_FRAME_WIDTH;
			frame_height_q  <= RST_FRAME_HEIGHT;
			alpha_enabled_q <= RST_ALPHA_EN;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_LUT_SIZE:      lut_size_q      <= cfg.data[LUT_BITS-1:0];
				REG_FRAME_WIDTH:   frame_width_q   <= cfg.data[PIX_BITS-1:0];
				REG_FRAME_HEIGHT:  frame_height_q  <= cfg.data[PIX_BITS-1:0];
				REG_ALPHA_ENABLED: alpha_enabled_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Cube size, saturated
	logic [NB-1:0] n_eff;
	logic [NB-1:0] d_eff;

	always_comb begin
		if (int'(lut_size_q) < LUT_SIZE_MIN) begin
			n_eff = NB'(LUT_SIZE_MIN);
		end else if (int'(lut_size_q) > MAX_LUT_SIZE) begin
			n_eff = NB'(MAX_LUT_SIZE);
		end else begin
			n_eff = NB'(lut_size_q);
		end
	end

	assign d_eff = n_eff - NB'(1);

	// Per cube size constants: n^3, reciprocals of n and n-1, FULL split by n-1
	logic [CB:0]         cube_tab [LUT_SIZE_MIN:MAX_LUT_SIZE];
	logic [CB-1:0]       rn_tab   [LUT_SIZE_MIN:MAX_LUT_SIZE];
	logic [COLOR_BITS-1:0] qf_tab [LUT_SIZE_MIN:MAX_LUT_SIZE];
	logic [NB-1:0]       rf_tab   [LUT_SIZE_MIN:MAX_LUT_SIZE];
	logic [SD:0]         rd_tab   [LUT_SIZE_MIN:MAX_LUT_SIZE];

	for (genvar g = LUT_SIZE_MIN; g <= MAX_LUT_SIZE; g++) begin : g_tab
		localparam longint unsigned CUBE_L = g * g * g;
		localparam longint unsigned RN_L   = (64'd1 << CB) / g;
		localparam longint unsigned QF_L   = FULL_L / (g - 1);
		localparam longint unsigned RF_L   = FULL_L % (g - 1);
		localparam longint unsigned RD_L   = (64'd1 << SD) / (g - 1);
		assign cube_tab[g] = CUBE_L[CB:0];
		assign rn_tab[g]   = RN_L[CB-1:0];
		assign qf_tab[g]   = QF_L[COLOR_BITS-1:0];
		assign rf_tab[g]   = RF_L[NB-1:0];
		assign rd_tab[g]   = RD_L[SD:0];
	end

	logic [CB:0]           n_cube;
	logic [CB-1:0]         n_rcp;
	logic [COLOR_BITS-1:0] full_quo;
	logic [NB-1:0]         full_rem;
	logic [SD:0]           d_rcp;

	assign n_cube   = cube_tab[n_eff];
	assign n_rcp    = rn_tab[n_eff];
	assign full_quo = qf_tab[n_eff];
	assign full_rem = rf_tab[n_eff];
	assign d_rcp    = rd_tab[n_eff];

	// Flow control
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, out_vld_q;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9, en_o;

	assign en_o  = !out_vld_q || col.ready;
	assign en_s9 = !vld_s9 || en_o;
	assign en_s8 = !vld_s8 || en_s9;
	assign en_s7 = !vld_s7 || en_s8;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign pix.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			vld_s9    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= pix.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
			if (en_s9) vld_s9 <= vld_s8;
			if (en_o)  out_vld_q <= vld_s9;
		end
	end

	// Stage 1: reciprocal products for x, y and width divided by patch size
	logic [2:0][PIX_BITS-1:0] dv_in;
	logic [2:0][PIX_BITS-1:0] dv_s1;
	logic [2:0][PPW-1:0]      prod_s1;
	logic                     outside_s1;

	assign dv_in = {frame_width_q, pix.pixel_y, pix.pixel_x};

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int k = 0; k < 3; k++) begin
				prod_s1[k] <= PPW'(dv_in[k]) * PPW'(MP);
			end
			dv_s1      <= dv_in;
			outside_s1 <= (pix.pixel_x >= frame_width_q) || (pix.pixel_y >= frame_height_q);
		end
	end

	// Stage 2: quotient correction
	logic [2:0][PIX_BITS-1:0] pq_est;
	logic [2:0][PIX_BITS-1:0] pq_rem;
	logic [2:0][PIX_BITS-1:0] pq_fix;
	logic [2:0][PIX_BITS-1:0] q_s2;
	logic                     outside_s2;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pq_est[k] = prod_s1[k][SP +: PIX_BITS];
			pq_rem[k] = dv_s1[k] - PIX_BITS'(pq_est[k] * P_C);
			pq_fix[k] = (pq_rem[k] >= P_C) ? pq_est[k] + PIX_BITS'(1) : pq_est[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			q_s2       <= pq_fix;
			outside_s2 <= outside_s1;
		end
	end

	// Stage 3: patch index
	logic [IB-1:0] idx_s3;
	logic          outside_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			idx_s3     <= IB'(q_s2[1]) * IB'(q_s2[2]) + IB'(q_s2[0]);
			outside_s3 <= outside_s2;
		end
	end

	// Stage 4: cube range check, first reciprocal product
	logic [CB-1:0]   v0_s4;
	logic [2*CB-1:0] p0_s4;
	logic            ip_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			ip_s4 <= !outside_s3 && (idx_s3 < IB'(n_cube));
			v0_s4 <= idx_s3[CB-1:0];
			p0_s4 <= (2*CB)'(idx_s3[CB-1:0]) * (2*CB)'(n_rcp);
		end
	end

	// Stage 5: idx / n and red digit
	logic [CB-1:0] q1_est, r1_raw, q1_fix, r1_fix;
	logic [CB-1:0] q1_s5;
	logic [NB-1:0] d0_s5;
	logic          ip_s5;

	always_comb begin
		q1_est = p0_s4[CB +: CB];
		r1_raw = v0_s4 - CB'(q1_est * CB'(n_eff));
		if (r1_raw >= CB'(n_eff)) begin
			q1_fix = q1_est + CB'(1);
			r1_fix = r1_raw - CB'(n_eff);
		end else begin
			q1_fix = q1_est;
			r1_fix = r1_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			q1_s5 <= q1_fix;
			d0_s5 <= r1_fix[NB-1:0];
			ip_s5 <= ip_s4;
		end
	end

	// Stage 6: second reciprocal product
	logic [2*CB-1:0] p1_s6;
	logic [CB-1:0]   q1_s6;
	logic [NB-1:0]   d0_s6;
	logic            ip_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			p1_s6 <= (2*CB)'(q1_s5) * (2*CB)'(n_rcp);
			q1_s6 <= q1_s5;
			d0_s6 <= d0_s5;
			ip_s6 <= ip_s5;
		end
	end

	// Stage 7: green and blue digits
	logic [CB-1:0] q2_est, r2_raw, q2_fix, r2_fix;
	logic [2:0][NB-1:0] dig_s7;
	logic               ip_s7;

	always_comb begin
		q2_est = p1_s6[CB +: CB];
		r2_raw = q1_s6 - CB'(q2_est * CB'(n_eff));
		if (r2_raw >= CB'(n_eff)) begin
			q2_fix = q2_est + CB'(1);
			r2_fix = r2_raw - CB'(n_eff);
		end else begin
			q2_fix = q2_est;
			r2_fix = r2_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			dig_s7[0] <= d0_s6;
			dig_s7[1] <= r2_fix[NB-1:0];
			dig_s7[2] <= q2_fix[NB-1:0];
			ip_s7     <= ip_s6;
		end
	end

	// Stage 8: k*FULL/(n-1) = k*quo + (k*rem)/(n-1)
	logic [2:0][COLOR_BITS-1:0] a_s8;
	logic [2:0][SD-1:0]         b_s8;
	logic                       ip_s8;

	always_ff @(posedge clk) begin
		if (en_s8) begin
			for (int k = 0; k < 3; k++) begin
				a_s8[k] <= COLOR_BITS'(AW'(dig_s7[k]) * AW'(full_quo));
				b_s8[k] <= SD'(dig_s7[k]) * SD'(full_rem);
			end
			ip_s8 <= ip_s7;
		end
	end

	// Stage 9: reciprocal product by n-1
	logic [2:0][PBW-1:0]        pb_s9;
	logic [2:0][COLOR_BITS-1:0] a_s9;
	logic [2:0][SD-1:0]         b_s9;
	logic                       ip_s9;

	always_ff @(posedge clk) begin
		if (en_s9) begin
			for (int k = 0; k < 3; k++) begin
				pb_s9[k] <= PBW'(b_s8[k]) * PBW'(d_rcp);
			end
			a_s9  <= a_s8;
			b_s9  <= b_s8;
			ip_s9 <= ip_s8;
		end
	end

	// Output register
	logic [2:0][SD-1:0]         qb_est, rb_raw, qb_fix;
	logic [2:0][COLOR_BITS-1:0] code;
	logic [COLOR_BITS-1:0]      red_q, green_q, blue_q, alpha_q;
	logic                       in_patch_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qb_est[k] = pb_s9[k][SD +: SD];
			rb_raw[k] = b_s9[k] - SD'(qb_est[k] * SD'(d_eff));
			qb_fix[k] = (rb_raw[k] >= SD'(d_eff)) ? qb_est[k] + SD'(1) : qb_est[k];
			code[k]   = a_s9[k] + COLOR_BITS'(qb_fix[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			red_q      <= ip_s9 ? code[0] : '0;
			green_q    <= ip_s9 ? code[1] : '0;
			blue_q     <= ip_s9 ? code[2] : '0;
			alpha_q    <= (ip_s9 && alpha_enabled_q) ? FULL : '0;
			in_patch_q <= ip_s9;
		end
	end

	assign col.valid      = out_vld_q;
	assign col.red_code   = red_q;
	assign col.green_code = green_q;
	assign col.blue_code  = blue_q;
	assign col.alpha_code = alpha_q;
	assign col.in_patch   = in_patch_q;

	// Checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.ready |-> (out_vld_q && !col.ready))
		else $error("input stalled while the pipeline has room");

	a_black_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(col.valid && !col.in_patch) |-> (col.red_code == '0 && col.green_code == '0 &&
		col.blue_code == '0 && col.alpha_code == '0))
		else $error("nonzero color outside a patch");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s7 && ip_s7) |-> (dig_s7[0] < n_eff && dig_s7[1] < n_eff && dig_s7[2] < n_eff))
		else $error("color digit not below cube size");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s9 && !en_s9) |=> (vld_s9 && $stable(a_s9) && $stable(ip_s9)))
		else $error("stage 9 item changed under back pressure");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the color cube chart generator: directed and random pixels.
module tb_top;
	import ccpg_pkg::*;

	localparam int CBITS        = DEF_COLOR_BITS;
	localparam int SETTLE       = 14;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 80;

	typedef struct packed {
		logic [CBITS-1:0] red;
		logic [CBITS-1:0] green;
		logic [CBITS-1:0] blue;
		logic [CBITS-1:0] alpha;
		logic             in_patch;
	} color_t;

	class chart_scoreboard;
		logic [LUT_BITS-1:0] lut_size;
		logic [PIX_BITS-1:0] frame_width;
		logic [PIX_BITS-1:0] frame_height;
		logic                alpha_en;
		color_t              pending_colors[$];
		int                  fails;

		function new();
			lut_size     = RST_LUT_SIZE;
			frame_width  = RST_FRAME_WIDTH;
			frame_height = RST_FRAME_HEIGHT;
			alpha_en     = RST_ALPHA_EN;
			fails        = 0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_LUT_SIZE:      lut_size = data[LUT_BITS-1:0];
				REG_FRAME_WIDTH:   frame_width = data[PIX_BITS-1:0];
				REG_FRAME_HEIGHT:  frame_height = data[PIX_BITS-1:0];
				REG_ALPHA_ENABLED: alpha_en = data[0];
				default: ;
			endcase
		endfunction

		function logic [CBITS-1:0] level(longint unsigned k, longint unsigned n);
			longint unsigned full;
			full = (64'd1 << CBITS) - 1;
			return CBITS'((k * full) / (n - 1));
		endfunction

		function void note_pixel(logic [PIX_BITS-1:0] x, logic [PIX_BITS-1:0] y);
			color_t          c;
			longint unsigned n;
			longint unsigned patch;
			c = '0;
			n = lut_size;
			if (n < LUT_SIZE_MIN)
				n = LUT_SIZE_MIN;
			if (n > DEF_MAX_LUT_SIZE)
				n = DEF_MAX_LUT_SIZE;
			if (x < frame_width && y < frame_height) begin
				patch = longint'(y / DEF_PATCH_SIZE) * longint'(frame_width / DEF_PATCH_SIZE)
					+ longint'(x / DEF_PATCH_SIZE);
				if (patch < n * n * n) begin
					c.red      = level(patch % n, n);
					c.green    = level((patch / n) % n, n);
					c.blue     = level((patch / n / n) % n, n);
					c.alpha    = alpha_en ? {CBITS{1'b1}} : '0;
					c.in_patch = 1'b1;
				end
			end
			pending_colors.push_back(c);
		endfunction

		function void compare_field(string name, longint unsigned exp_v, longint unsigned got_v);
			if (exp_v != got_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, got_v);
				fails++;
			end
		endfunction

		function void check_color(color_t got);
			color_t exp_c;
			if (pending_colors.size() == 0) begin
				$error("color transfer with no pixel outstanding");
				fails++;
				return;
			end
			exp_c = pending_colors.pop_front();
			compare_field("red_code", exp_c.red, got.red);
			compare_field("green_code", exp_c.green, got.green);
			compare_field("blue_code", exp_c.blue, got.blue);
			compare_field("alpha_code", exp_c.alpha, got.alpha);
			compare_field("in_patch", exp_c.in_patch, got.in_patch);
		endfunction

		function int pending();
			return pending_colors.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic steady;
	int   cycles = 0;

	chart_scoreboard sb;

	ccpg_pix_if pix_ch();
	ccpg_col_if #(.COLOR_BITS(CBITS)) col_ch();
	ccpg_cfg_if cfg_ch();

	color_cube_patch_pattern_generator #(
		.PATCH_SIZE(DEF_PATCH_SIZE),
		.MAX_LUT_SIZE(DEF_MAX_LUT_SIZE),
		.COLOR_BITS(CBITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.pix(pix_ch),
		.col(col_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		col_ch.ready <= steady || ($urandom_range(0, 99) >= 27);
	end

	always @(posedge clk) begin
		if (arst_n && col_ch.valid && col_ch.ready)
			sb.check_color({col_ch.red_code, col_ch.green_code, col_ch.blue_code,
				col_ch.alpha_code, col_ch.in_patch});
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_pixel(input int x, input int y);
		while (!steady && $urandom_range(0, 99) < 27) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid   <= 1'b1;
		pix_ch.pixel_x <= PIX_BITS'(x);
		pix_ch.pixel_y <= PIX_BITS'(y);
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
		sb.note_pixel(PIX_BITS'(x), PIX_BITS'(y));
	endtask

	task automatic drain();
		pix_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= CFG_DATA_BITS'(data);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		sb.set_register(idx, CFG_DATA_BITS'(data));
	endtask

	task automatic apply_setting(input int lut, input int w, input int h, input int alpha);
		drain();
		write_reg(REG_LUT_SIZE, lut);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_ALPHA_ENABLED, alpha);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		int n;
		int n_eff;
		int w;
		int h;
		int per_row;
		int rows;
		sb             = new();
		steady         = 1'b0;
		arst_n         = 1'b0;
		pix_ch.valid   = 1'b0;
		pix_ch.pixel_x = '0;
		pix_ch.pixel_y = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = REG_LUT_SIZE;
		cfg_ch.data    = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: 33-cube, 189 patches per row, the last row runs past the cube
		send_pixel(0, 0);
		send_pixel(6, 6);
		send_pixel(7, 0);
		send_pixel(1322, 0);
		send_pixel(0, 7);
		send_pixel(182, 1330);
		send_pixel(189, 1330);
		send_pixel(1322, 1329);
		send_pixel(1322, 1336);
		send_pixel(1323, 0);
		send_pixel(0, 1337);
		send_pixel(4095, 4095);
		send_pixel(2730, 1365);
		send_pixel(1365, 2730);

		// cube size below range, frame narrower than a patch, alpha off
		apply_setting(0, 6, 20, 0);
		send_pixel(0, 0);
		send_pixel(5, 19);
		send_pixel(6, 0);
		send_pixel(3, 14);

		// cube size above range, widest frame
		apply_setting(63, 4095, 4095, 1);
		send_pixel(224, 0);
		send_pixel(4094, 4094);
		send_pixel(4095, 0);

		apply_setting(1, 7, 7, 1);
		send_pixel(6, 6);
		send_pixel(7, 6);

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: n = 8;
				1: n = 33;
				2: n = $urandom_range(0, 63);
				default: n = $urandom_range(8, 33);
			endcase
			n_eff = (n < LUT_SIZE_MIN) ? LUT_SIZE_MIN : (n > DEF_MAX_LUT_SIZE) ? DEF_MAX_LUT_SIZE : n;
			if ($urandom_range(0, 3) == 0)
				w = $urandom_range(1, 4095);
			else
				w = DEF_PATCH_SIZE * $urandom_range(1, 4095 / DEF_PATCH_SIZE);
			per_row = w / DEF_PATCH_SIZE;
			if (per_row == 0) begin
				h = $urandom_range(1, 4095);
			end else begin
				rows = (n_eff * n_eff * n_eff + per_row - 1) / per_row + 1;
				h = (rows * DEF_PATCH_SIZE > 4095) ? 4095 : rows * DEF_PATCH_SIZE;
			end
			apply_setting(n, w, h, p % 2);
			steady = (p == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 99) < 85)
					send_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1));
				else
					send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
			end
			steady = 1'b0;
		end

		drain();
		if (sb.fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
